// ----- design/record_deframer_assert.svh -----
// assertion macros used by the record deframer top level
`ifndef RECORD_DEFRAMER_ASSERT_SVH
`define RECORD_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rd_pkg.sv -----
// shared types, codes and helpers for the record deframer
package rd_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int HOLD_DEPTH  = MAX_PATTERN - 1;
    localparam int CNT_W       = $clog2(MAX_PATTERN);

    // framing modes
    localparam logic [1:0] MODE_DELIM   = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_FIXED   = 2'd2;

    // input item kinds
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_DELIM   = 3'd1;
    localparam logic [2:0] REG_PATTERN = 3'd2;
    localparam logic [2:0] REG_PLEN    = 3'd3;
    localparam logic [2:0] REG_RLEN    = 3'd4;

    typedef struct packed {
        logic clear;
        logic load_new;
        logic load_shift;
        logic active;
    } cell_ctrl_t;

    typedef struct packed {
        logic       record_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } result_t;

    // number of window cells in use for a given pattern length
    function automatic logic [CNT_W-1:0] cap_of(input logic [3:0] plen);
        int n;
        n = int'(plen);
        if (n < 1) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return CNT_W'(n - 1);
    endfunction

    // pattern byte at a position, zero past the eighth byte
    function automatic logic [7:0] pattern_byte(input logic [63:0] pat,
                                                input logic [CNT_W-1:0] idx);
        int k;
        k = int'(idx);
        if (k >= 8) return 8'h00;
        return pat[8*k +: 8];
    endfunction

endpackage

// ----- design/rd_cell.sv -----
// one byte cell of the pattern window with its link in the match chain
module rd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rd_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         new_byte,
    input  logic [7:0]         nbr_byte,
    input  logic [7:0]         pat_byte,
    input  logic               match_in,
    output logic [7:0]         held_byte,
    output logic               match_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            byte_next = 8'h00;
        end
        else if (ctrl.load_new)
        begin
            byte_next = new_byte;
        end
        else if (ctrl.load_shift)
        begin
            byte_next = nbr_byte;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign held_byte = byte_reg;
    // cells past the window length do not take part in the compare
    assign match_out = match_in & (~ctrl.active | (byte_reg == pat_byte));

endmodule

// ----- design/rd_out_skid.sv -----
// output register with a skid entry between the framing logic and the stream
module rd_out_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  rd_pkg::result_t in_res,
    input  logic            out_ready,
    output logic            out_valid,
    output rd_pkg::result_t out_res,
    output logic            full
);

    logic            out_valid_reg;
    logic            out_valid_next;
    rd_pkg::result_t out_res_reg;
    rd_pkg::result_t out_res_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    rd_pkg::result_t skid_res_reg;
    rd_pkg::result_t skid_res_next;
    logic            out_free;

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign full      = skid_valid_reg;

endmodule

// ----- design/record_deframer.sv -----
// record deframer top level: register port, window cell row, output skid
//
// takes one stream byte per item on s_axis and gives at most one item on m_axis
// s_axis_tuser selects data byte or clear; a clear empties the window and counter
// m_axis_tdata carries the payload byte, m_axis_tuser says it is valid payload,
// m_axis_tlast marks the end of a record (a dropped delimiter or a matched
// pattern yields an item with tuser low, tdata zero and tlast high)
// modes come from the apb registers: single delimiter byte, multi-byte pattern,
// fixed record length; writing mode or pattern_length empties the window
// an accepted item's result is registered in the output stage; throughput: one
// item per cycle in every mode while s_axis_tready is high; the pattern window is
// a row of byte cells shifted together and compared in parallel via a match chain
// in pattern mode the first pattern_length-1 bytes after a clear give no item
// a stall on m_axis is absorbed by a one-entry skid stage; s_axis_tready drops
// only while that skid entry is occupied
// reset clears the window, the counters and the output stage and loads the
// register defaults; no clearing pass is needed
`include "record_deframer_assert.svh"

module record_deframer (
    input  logic        clk,
    input  logic        rst_n,
    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // op
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // record_end
);

    localparam int CW = rd_pkg::CNT_W;
    localparam int HD = rd_pkg::HOLD_DEPTH;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [7:0]  delim_reg;
    logic [63:0] pattern_reg;
    logic [3:0]  plen_reg;
    logic [31:0] rlen_reg;
    logic        cfg_wr;
    logic        cfg_clear;

    // framing state
    logic [CW-1:0] held_count_reg;
    logic [CW-1:0] held_count_next;
    logic [31:0]   record_count_reg;
    logic [31:0]   record_count_next;

    logic            acc;
    logic            skid_full;
    logic            res_valid;
    rd_pkg::result_t res;
    rd_pkg::result_t out_res;
    logic            fill_en;
    logic            shift_en;
    logic            clr_all;

    logic [CW-1:0] cap;
    logic          match;
    logic [7:0]    held [HD];
    logic          mchain [HD+1];
    rd_pkg::cell_ctrl_t cell_ctrl [HD];

    logic [32:0] cnt_sum;
    logic [31:0] rl_eff;
    logic        rec_last;

    // ---------------------------------------------------------------- apb port
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign cfg_clear = cfg_wr & ((paddr[5:3] == rd_pkg::REG_MODE)
                               | (paddr[5:3] == rd_pkg::REG_PLEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rd_pkg::MODE_DELIM;
            delim_reg   <= 8'd10;
            pattern_reg <= 64'd0;
            plen_reg    <= 4'd1;
            rlen_reg    <= 32'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                rd_pkg::REG_MODE:    mode_reg    <= pwdata[1:0];
                rd_pkg::REG_DELIM:   delim_reg   <= pwdata[7:0];
                rd_pkg::REG_PATTERN: pattern_reg <= pwdata;
                rd_pkg::REG_PLEN:    plen_reg    <= pwdata[3:0];
                rd_pkg::REG_RLEN:    rlen_reg    <= pwdata[31:0];
                default: ;  // unmapped addresses are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            rd_pkg::REG_MODE:    prdata = {62'd0, mode_reg};
            rd_pkg::REG_DELIM:   prdata = {56'd0, delim_reg};
            rd_pkg::REG_PATTERN: prdata = pattern_reg;
            rd_pkg::REG_PLEN:    prdata = {60'd0, plen_reg};
            rd_pkg::REG_RLEN:    prdata = {32'd0, rlen_reg};
            default:             prdata = 64'd0;
        endcase
    end

    // ---------------------------------------------------------------- window cells
    // cell 0 holds the oldest byte; cap is the number of cells in use
    assign cap       = rd_pkg::cap_of(plen_reg);
    // the newest byte is compared against the last pattern byte at the chain head
    assign mchain[0] = (s_axis_tdata == rd_pkg::pattern_byte(pattern_reg, cap));
    assign match     = mchain[HD];

    for (genvar i = 0; i < HD; i++)
    begin : g_cell
        logic [7:0] nbr;

        if (i == HD - 1)
        begin : g_tail
            assign nbr = 8'h00;
        end
        else
        begin : g_mid
            assign nbr = held[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].clear      = clr_all;
            cell_ctrl[i].active     = (i < int'(cap));
            // a filling byte lands at the fill position, a shifted-in one at the top
            cell_ctrl[i].load_new   = (fill_en & (held_count_reg == CW'(i)))
                                    | (shift_en & ((i + 1) == int'(cap)));
            cell_ctrl[i].load_shift = shift_en & ((i + 1) < int'(cap));
        end

        rd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .new_byte  (s_axis_tdata),
            .nbr_byte  (nbr),
            .pat_byte  (rd_pkg::pattern_byte(pattern_reg, CW'(i))),
            .match_in  (mchain[i]),
            .held_byte (held[i]),
            .match_out (mchain[i+1])
        );
    end

    // ---------------------------------------------------------------- fixed length count
    assign rl_eff   = (rlen_reg == 32'd0) ? 32'd1 : rlen_reg;
    assign cnt_sum  = {1'b0, record_count_reg} + 33'd1;
    // a counter wrap also closes the record
    assign rec_last = cnt_sum[32] | (cnt_sum[31:0] >= rl_eff);

    // ---------------------------------------------------------------- item processing
    assign s_axis_tready = ~skid_full;
    assign acc           = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        res               = '0;
        res_valid         = 1'b0;
        fill_en           = 1'b0;
        shift_en          = 1'b0;
        clr_all           = 1'b0;
        held_count_next   = held_count_reg;
        record_count_next = record_count_reg;

        if (acc)
        begin
            if (s_axis_tuser == rd_pkg::OP_CLEAR)
            begin
                clr_all           = 1'b1;
                held_count_next   = '0;
                record_count_next = 32'd0;
            end
            else
            begin
                unique case (mode_reg)
                    rd_pkg::MODE_DELIM:
                    begin
                        res_valid = 1'b1;
                        if (s_axis_tdata == delim_reg)
                        begin
                            res.record_end = 1'b1;
                        end
                        else
                        begin
                            res.out_byte   = s_axis_tdata;
                            res.byte_valid = 1'b1;
                        end
                    end
                    rd_pkg::MODE_PATTERN:
                    begin
                        priority if (held_count_reg < cap)
                        begin
                            // window still filling
                            fill_en         = 1'b1;
                            held_count_next = held_count_reg + CW'(1);
                        end
                        else if (match)
                        begin
                            res_valid       = 1'b1;
                            res.record_end  = 1'b1;
                            clr_all         = 1'b1;
                            held_count_next = '0;
                        end
                        else if (cap == '0)
                        begin
                            // one-byte pattern: no window, pass through
                            res_valid      = 1'b1;
                            res.out_byte   = s_axis_tdata;
                            res.byte_valid = 1'b1;
                        end
                        else
                        begin
                            res_valid       = 1'b1;
                            res.out_byte    = held[0];
                            res.byte_valid  = 1'b1;
                            shift_en        = 1'b1;
                            held_count_next = cap;
                        end
                    end
                    default:
                    begin
                        // fixed length, also taken by the unused mode code
                        res_valid         = 1'b1;
                        res.out_byte      = s_axis_tdata;
                        res.byte_valid    = 1'b1;
                        res.record_end    = rec_last;
                        record_count_next = rec_last ? 32'd0 : cnt_sum[31:0];
                    end
                endcase
            end
        end

        // mode or pattern length writes discard held bytes and the counter
        if (cfg_clear)
        begin
            clr_all           = 1'b1;
            held_count_next   = '0;
            record_count_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg   <= '0;
            record_count_reg <= 32'd0;
        end
        else
        begin
            held_count_reg   <= held_count_next;
            record_count_reg <= record_count_next;
        end
    end

    // ---------------------------------------------------------------- output stage
    rd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .full      (skid_full)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = out_res.byte_valid;
    assign m_axis_tlast = out_res.record_end;

    // ---------------------------------------------------------------- assertions
    `RD_ASSERT_IMPLY(a_held_within_cap, clk, rst_n, 1'b1, held_count_reg <= cap,
        "held byte count exceeds window length")
    `RD_ASSERT_IMPLY(a_marker_item_form, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        (m_axis_tdata == 8'h00) && m_axis_tlast, "non-payload item is not a bare record end")
    `RD_ASSERT_NEXT(a_match_empties, clk, rst_n,
        acc && (s_axis_tuser == rd_pkg::OP_DATA) && (mode_reg == rd_pkg::MODE_PATTERN)
        && (held_count_reg >= cap) && match,
        held_count_reg == '0, "window not emptied after a pattern match")

endmodule
